FILE: rtl/pfcw_pkg.sv
`timescale 1ns / 1ps
package pfcw_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES = 8;
	localparam int CELLS = COLUMNS * PAGES;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W = $clog2(CELLS);

	// Command queue between front and back; depth must be a power of two.
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = CQ_PTR_W + 1;

	// Result queue at the output; depth must be a power of two.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = RQ_PTR_W + 1;

	localparam logic [2:0] KIND_SET = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_FILL = 3'd2;
	localparam logic [2:0] KIND_INVERT = 3'd3;
	localparam logic [2:0] KIND_READ = 3'd4;

	localparam logic [2:0] OP_NOP = 3'd0;
	localparam logic [2:0] OP_SET = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_FILL = 3'd3;
	localparam logic [2:0] OP_INVERT = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] x_first;
		logic [6:0] x_last;
		logic [2:0] page_first;
		logic [2:0] page_last;
		logic [7:0] column_byte;
		logic       invert_write;
	} item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [6:0] cursor_column;
		logic [2:0] cursor_page;
	} result_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PG_W-1:0]  pg;
	} cursor_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_b;
		logic [PG_W-1:0]  pg_a;
		logic [PG_W-1:0]  pg_b;
		logic [7:0]       data;
	} cmd_t;

	function automatic logic [COL_W-1:0] clamp_col(logic [6:0] x);
		if (int'(x) > COLUMNS - 1) begin
			return COL_W'(COLUMNS - 1);
		end
		return COL_W'(x);
	endfunction

	function automatic logic [PG_W-1:0] clamp_page(logic [2:0] p);
		if (int'(p) > PAGES - 1) begin
			return PG_W'(PAGES - 1);
		end
		return PG_W'(p);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] col, logic [PG_W-1:0] pg);
		return ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	// Step the cursor by one cell; the last cell of the store is sticky.
	function automatic cursor_t advance(cursor_t c);
		cursor_t n;
		n = c;
		if (int'(c.col) == COLUMNS - 1) begin
			if (int'(c.pg) != PAGES - 1) begin
				n.col = '0;
				n.pg = c.pg + 1'b1;
			end
		end else begin
			n.col = c.col + 1'b1;
		end
		return n;
	endfunction

endpackage

FILE: rtl/pfcw_ram.sv
`timescale 1ns / 1ps
module pfcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/pfcw_front.sv
`timescale 1ns / 1ps
module pfcw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  pfcw_pkg::item_t item,
	input  logic           hold,
	output logic           cmd_valid,
	output pfcw_pkg::cmd_t cmd,
	input  logic           cmd_take
);
	import pfcw_pkg::*;

	cmd_t                dec;
	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                push_ok;

	// Clamp coordinates and fold the corner cases of invert rectangle into simpler ops.
	always_comb begin
		dec.op = OP_NOP;
		dec.col_a = clamp_col(item.x_first);
		dec.col_b = clamp_col(item.x_last);
		dec.pg_a = clamp_page(item.page_first);
		dec.pg_b = clamp_page(item.page_last);
		dec.data = item.column_byte;
		case (item.kind)
			KIND_SET: begin
				dec.op = OP_SET;
			end
			KIND_WRITE: begin
				dec.op = OP_WRITE;
				if (item.invert_write) begin
					dec.data = ~item.column_byte;
				end
			end
			KIND_FILL: begin
				dec.op = OP_FILL;
			end
			KIND_INVERT: begin
				// An empty column range only moves the cursor to the left column of the
				// bottom page; an empty page range leaves the store and the cursor as they are.
				if (dec.pg_a <= dec.pg_b) begin
					if (dec.col_a <= dec.col_b) begin
						dec.op = OP_INVERT;
					end else begin
						dec.op = OP_SET;
						dec.pg_a = dec.pg_b;
					end
				end
			end
			KIND_READ: begin
				dec.op = OP_READ;
			end
			default: begin
				dec.op = OP_NOP;
			end
		endcase
	end

	assign full = (count_q == CQ_CNT_W'(CQ_DEPTH)) || hold;
	assign push_ok = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd = cq_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CQ_CNT_W'(push_ok) - CQ_CNT_W'(cmd_take);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			cq_q[wr_ptr_q] <= dec;
		end
	end

endmodule

FILE: rtl/pfcw_back.sv
`timescale 1ns / 1ps
module pfcw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  pfcw_pkg::cmd_t   cmd,
	output logic             cmd_take,
	output logic             clearing,
	output logic             empty,
	input  logic             pop,
	output pfcw_pkg::result_t result
);
	import pfcw_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_INVERT = 2'd3;

	logic [1:0]          state_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic [7:0]          fill_byte_q;
	cursor_t             cur_q;
	cursor_t             nxt_cur;
	cursor_t             walk_q;
	logic [COL_W-1:0]    x_lo_q;
	logic [COL_W-1:0]    x_hi_q;
	logic [PG_W-1:0]     pg_hi_q;

	logic                res_valid_s1;
	logic                res_read_s1;
	cursor_t             res_cur_s1;
	logic                wb_valid_s1;
	logic [ADDR_W-1:0]   wb_addr_s1;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [7:0]          ram_wdata;
	logic [7:0]          ram_rdata;

	result_t             rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] rq_wr_q;
	logic [RQ_PTR_W-1:0] rq_rd_q;
	logic [RQ_CNT_W-1:0] rq_cnt_q;
	result_t             rq_in;
	logic                pop_ok;

	logic                room;
	logic                sweep_last;
	logic                walk_last;
	logic                emit;
	logic                emit_read;

	// A command is started only when its result has a guaranteed slot, so a long
	// sweep never has to stall at its end.
	assign room = (rq_cnt_q + RQ_CNT_W'(res_valid_s1)) < RQ_CNT_W'(RQ_DEPTH);
	assign cmd_take = (state_q == ST_RUN) && cmd_valid && room && !wb_valid_s1;
	assign sweep_last = (sweep_q == ADDR_W'(CELLS - 1));
	assign walk_last = (walk_q.col == x_hi_q) && (walk_q.pg == pg_hi_q);
	assign clearing = (state_q == ST_CLEAR);

	always_comb begin
		nxt_cur = cur_q;
		emit = 1'b0;
		emit_read = 1'b0;
		ram_we = 1'b0;
		ram_waddr = cell_addr(cur_q.col, cur_q.pg);
		ram_wdata = cmd.data;
		ram_raddr = cell_addr(cmd.col_a, cmd.pg_a);
		// The invert walk writes back the complement in the cycle after each read.
		if (wb_valid_s1) begin
			ram_we = 1'b1;
			ram_waddr = wb_addr_s1;
			ram_wdata = ~ram_rdata;
		end
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '0;
			end
			ST_FILL: begin
				ram_we = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = fill_byte_q;
				if (sweep_last) begin
					emit = 1'b1;
					nxt_cur.col = COL_W'(COLUMNS - 1);
					nxt_cur.pg = PG_W'(PAGES - 1);
				end
			end
			ST_INVERT: begin
				ram_raddr = cell_addr(walk_q.col, walk_q.pg);
				if (walk_last) begin
					emit = 1'b1;
					nxt_cur = advance(walk_q);
				end
			end
			ST_RUN: begin
				if (cmd_take) begin
					emit = (cmd.op != OP_FILL) && (cmd.op != OP_INVERT);
					case (cmd.op)
						OP_SET: begin
							nxt_cur.col = cmd.col_a;
							nxt_cur.pg = cmd.pg_a;
						end
						OP_WRITE: begin
							ram_we = 1'b1;
							nxt_cur = advance(cur_q);
						end
						OP_READ: begin
							emit_read = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			cur_q <= '0;
			res_valid_s1 <= 1'b0;
			wb_valid_s1 <= 1'b0;
		end else begin
			cur_q <= nxt_cur;
			res_valid_s1 <= emit;
			wb_valid_s1 <= (state_q == ST_INVERT);
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					if (sweep_last) begin
						state_q <= ST_RUN;
						sweep_q <= '0;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_INVERT: begin
					if (walk_last) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd_take && (cmd.op == OP_FILL)) begin
						state_q <= ST_FILL;
						sweep_q <= '0;
					end
					if (cmd_take && (cmd.op == OP_INVERT)) begin
						state_q <= ST_INVERT;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		res_read_s1 <= emit_read;
		res_cur_s1 <= nxt_cur;
		wb_addr_s1 <= ram_raddr;
		if (cmd_take) begin
			fill_byte_q <= cmd.data;
			x_lo_q <= cmd.col_a;
			x_hi_q <= cmd.col_b;
			pg_hi_q <= cmd.pg_b;
			walk_q.col <= cmd.col_a;
			walk_q.pg <= cmd.pg_a;
		end else if (state_q == ST_INVERT) begin
			if (walk_q.col == x_hi_q) begin
				walk_q.col <= x_lo_q;
				walk_q.pg <= walk_q.pg + 1'b1;
			end else begin
				walk_q.col <= walk_q.col + 1'b1;
			end
		end
	end

	pfcw_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result queue: the read data joins the cursor in the cycle after the command ran.
	always_comb begin
		rq_in.read_byte = res_read_s1 ? ram_rdata : 8'h00;
		rq_in.cursor_column = 7'(res_cur_s1.col);
		rq_in.cursor_page = 3'(res_cur_s1.pg);
	end

	assign empty = (rq_cnt_q == '0);
	assign pop_ok = pop && !empty;
	assign result = rq_q[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q <= '0;
			rq_rd_q <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (res_valid_s1) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (pop_ok) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			rq_cnt_q <= rq_cnt_q + RQ_CNT_W'(res_valid_s1) - RQ_CNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_s1) begin
			rq_q[rq_wr_q] <= rq_in;
		end
	end

endmodule

FILE: rtl/page_framebuffer_cursor_writer_top.sv
// Set cursor, write column, read and no-op words run at one per cycle while the result
// queue has room and no fill or invert runs; each word passes a two-deep command queue
// and a result register before its result can be popped. Fill holds the back end for the
// command and a sweep over every store byte; invert rectangle holds it for the command,
// a read of each byte and the final write-back. After reset the store is cleared to zero,
// full stays high meanwhile, and the cursor starts at column 0 of page 0.
`timescale 1ns / 1ps
module page_framebuffer_cursor_writer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pfcw_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output pfcw_pkg::result_t result
);
	import pfcw_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic clearing;

	pfcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.hold      (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	pfcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: rtl/pfcw_checker.sv
`timescale 1ns / 1ps
module pfcw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input pfcw_pkg::result_t result
);
	import pfcw_pkg::*;

	logic [4:0] outstanding_q;
	logic       push_ok;
	logic       pop_ok;

	assign push_ok = push && !full;
	assign pop_ok = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 5'(push_ok) - 5'(pop_ok);
		end
	end

	// The clearing pass holds off input and nothing is waiting right after reset.
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (full && empty))
		else $error("block not full and empty right after reset");

	// Every result word must be backed by an accepted input word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (outstanding_q != '0))
		else $error("result shown with no word outstanding");

	// A word into an idle block cannot reach the result side by the following cycle.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q == '0 && empty) |=> empty)
		else $error("result appeared too early");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind page_framebuffer_cursor_writer_top pfcw_checker u_pfcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: tb/page_framebuffer_cursor_writer_top_test.sv
`timescale 1ns / 1ps
module page_framebuffer_cursor_writer_top_test;
	import pfcw_pkg::*;

	// Kinds past the read command are accepted but change nothing.
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	class frame_shadow;
		bit [7:0]       cells [CELLS];
		bit [COL_W-1:0] col;
		bit [PG_W-1:0]  pg;
		result_t        owed [$];
		int             mismatches;
		int             checked;
		int             kind_seen [8];

		function new();
			foreach (cells[i]) cells[i] = 8'h00;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			col = '0;
			pg = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int clip_col(int x);
			return (x > COLUMNS - 1) ? COLUMNS - 1 : x;
		endfunction

		function int clip_pg(int p);
			return (p > PAGES - 1) ? PAGES - 1 : p;
		endfunction

		// The cursor stops for good at the last column of the last page.
		function void step_cursor();
			if (int'(col) < COLUMNS - 1) begin
				col = col + 1'b1;
			end else if (int'(pg) < PAGES - 1) begin
				col = '0;
				pg = pg + 1'b1;
			end
		endfunction

		function void note_command(item_t w);
			int xf, xl, pf, pl;
			result_t r;
			xf = clip_col(int'(w.x_first));
			xl = clip_col(int'(w.x_last));
			pf = clip_pg(int'(w.page_first));
			pl = clip_pg(int'(w.page_last));
			r = '0;
			kind_seen[w.kind]++;
			case (w.kind)
			KIND_SET: begin
				col = COL_W'(xf);
				pg = PG_W'(pf);
			end
			KIND_WRITE: begin
				cells[int'(pg) * COLUMNS + int'(col)] =
					w.invert_write ? ~w.column_byte : w.column_byte;
				step_cursor();
			end
			KIND_FILL: begin
				foreach (cells[i]) cells[i] = w.column_byte;
				col = COL_W'(COLUMNS - 1);
				pg = PG_W'(PAGES - 1);
			end
			KIND_INVERT: begin
				if (pf <= pl) begin
					for (int p = pf; p <= pl; p++) begin
						for (int c = xf; c <= xl; c++) begin
							cells[p * COLUMNS + c] ^= 8'hFF;
						end
					end
					// Cursor ends as if each row were written; xf > xl leaves it at (xf, pl).
					col = COL_W'((xf <= xl) ? xl : xf);
					pg = PG_W'(pl);
					if (xf <= xl) begin
						step_cursor();
					end
				end
			end
			KIND_READ: begin
				r.read_byte = cells[pf * COLUMNS + xf];
			end
			default: begin
			end
			endcase
			r.cursor_column = 7'(col);
			r.cursor_page = 3'(pg);
			owed.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				mismatches++;
				$display("%0t: word popped with nothing owed: expected none, actual %h",
					$time, got);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.read_byte !== want.read_byte) begin
				mismatches++;
				$display("%0t: read_byte expected %h actual %h",
					$time, want.read_byte, got.read_byte);
			end
			if (got.cursor_column !== want.cursor_column) begin
				mismatches++;
				$display("%0t: cursor_column expected %0d actual %0d",
					$time, want.cursor_column, got.cursor_column);
			end
			if (got.cursor_page !== want.cursor_page) begin
				mismatches++;
				$display("%0t: cursor_page expected %0d actual %0d",
					$time, want.cursor_page, got.cursor_page);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	item_t   item = '0;
	logic    full;
	logic    empty;
	result_t result;

	frame_shadow shadow = new();
	int send_calm = 0;
	int take_calm = 0;

	page_framebuffer_cursor_writer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly a random wait per word, with runs of back-to-back words now and then.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 80);
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic item_t make_word(logic [2:0] kind, logic [6:0] xf, logic [6:0] xl,
			logic [2:0] pf, logic [2:0] pl, logic [7:0] b, logic inv);
		item_t w;
		w.kind = kind;
		w.x_first = xf;
		w.x_last = xl;
		w.page_first = pf;
		w.page_last = pl;
		w.column_byte = b;
		w.invert_write = inv;
		return w;
	endfunction

	// Leaves push high on return so a following word can go out in the next cycle.
	task automatic send_word(item_t w);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		shadow.note_command(w);
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			shadow.check_result(result);
		end
	end

	initial begin
		int sent;
		int pick;
		int c;
		int p;
		item_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Cleared store, page wrap, the sticky last cell and the invert corner cases.
		send_word(make_word(KIND_READ, 7'd0, 7'd127, 3'd0, 3'd7, 8'hFF, 1'b1));
		send_word(make_word(KIND_READ, 7'd127, 7'd0, 3'd7, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_SET, 7'd126, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_WRITE, 7'd0, 7'd0, 3'd0, 3'd0, 8'hA5, 1'b0));
		send_word(make_word(KIND_WRITE, 7'd0, 7'd0, 3'd0, 3'd0, 8'h0F, 1'b1));
		send_word(make_word(KIND_READ, 7'd126, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_READ, 7'd127, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_SET, 7'd127, 7'd127, 3'd7, 3'd7, 8'hFF, 1'b1));
		send_word(make_word(KIND_WRITE, 7'd0, 7'd0, 3'd0, 3'd0, 8'hFF, 1'b0));
		send_word(make_word(KIND_WRITE, 7'd0, 7'd0, 3'd0, 3'd0, 8'h00, 1'b1));
		send_word(make_word(KIND_INVERT, 7'd0, 7'd127, 3'd0, 3'd7, 8'h00, 1'b0));
		send_word(make_word(KIND_READ, 7'd0, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_INVERT, 7'd100, 7'd5, 3'd2, 3'd3, 8'h00, 1'b0));
		send_word(make_word(KIND_INVERT, 7'd10, 7'd20, 3'd5, 3'd2, 8'h00, 1'b0));
		send_word(make_word(KIND_INVERT, 7'd0, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_INVERT, 7'd127, 7'd127, 3'd3, 3'd3, 8'h00, 1'b0));
		send_word(make_word(KIND_READ, 7'd127, 7'd0, 3'd3, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_FILL, 7'd5, 7'd9, 3'd1, 3'd2, 8'h3C, 1'b1));
		send_word(make_word(KIND_READ, 7'd64, 7'd0, 3'd4, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_FILL, 7'd0, 7'd0, 3'd0, 3'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_SPARE_LO, 7'd33, 7'd66, 3'd2, 3'd5, 8'h5A, 1'b1));
		send_word(make_word(KIND_SPARE_HI, 7'd127, 7'd127, 3'd7, 3'd7, 8'hFF, 1'b1));
		send_word(make_word(KIND_WRITE, 7'd0, 7'd0, 3'd0, 3'd0, 8'h80, 1'b0));
		send_word(make_word(KIND_READ, 7'd127, 7'd127, 3'd7, 3'd7, 8'h00, 1'b0));

		sent = 0;
		while (sent < 1500) begin
			w = make_word(3'($urandom_range(0, 4)), 7'($urandom), 7'($urandom),
				3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
			if ($urandom_range(0, 3) == 0) begin
				// Place the cursor, often near a page end, write a run, read some back.
				w.kind = KIND_SET;
				if ($urandom_range(0, 4) < 2) begin
					w.x_first = 7'($urandom_range(112, 127));
				end
				if ($urandom_range(0, 9) < 3) begin
					w.page_first = 3'd7;
				end
				send_word(w);
				sent++;
				repeat ($urandom_range(1, 24)) begin
					send_word(make_word(KIND_WRITE, 7'($urandom), 7'($urandom), 3'($urandom),
						3'($urandom), 8'($urandom), 1'($urandom)));
					sent++;
				end
				repeat ($urandom_range(1, 4)) begin
					c = int'(shadow.col) - $urandom_range(0, 8);
					p = int'(shadow.pg);
					if (c < 0) begin
						c = 0;
					end
					if ($urandom_range(0, 1) == 0) begin
						c = $urandom_range(0, 127);
						p = $urandom_range(0, 7);
					end
					send_word(make_word(KIND_READ, 7'(c), 7'($urandom), 3'(p), 3'($urandom),
						8'($urandom), 1'($urandom)));
					sent++;
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					w.kind = KIND_SET;
				end else if (pick < 42) begin
					w.kind = KIND_WRITE;
				end else if (pick < 67) begin
					w.kind = KIND_READ;
				end else if (pick < 94) begin
					w.kind = KIND_INVERT;
					// Keep most rectangles small; the rest are fully random windows.
					if ($urandom_range(0, 3) != 0) begin
						c = int'(w.x_first) + $urandom_range(0, 12);
						p = int'(w.page_first) + $urandom_range(0, 2);
						w.x_last = 7'((c > 127) ? 127 : c);
						w.page_last = 3'((p > 7) ? 7 : p);
					end
				end else if (pick < 96) begin
					w.kind = KIND_FILL;
				end else begin
					w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
				end
				send_word(w);
				sent++;
			end
		end
		push <= 1'b0;

		while (shadow.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Commands: %0d set, %0d write, %0d fill, %0d invert, %0d read, %0d unused.",
			shadow.kind_seen[KIND_SET], shadow.kind_seen[KIND_WRITE],
			shadow.kind_seen[KIND_FILL], shadow.kind_seen[KIND_INVERT],
			shadow.kind_seen[KIND_READ], shadow.kind_seen[5] + shadow.kind_seen[6] +
			shadow.kind_seen[7]);
		$display("Checked %0d result words, %0d field mismatches.",
			shadow.checked, shadow.mismatches);
		if (shadow.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Timed out with %0d result words still owed.", shadow.owed.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pfcw_pkg.sv
rtl/pfcw_ram.sv
rtl/pfcw_front.sv
rtl/pfcw_back.sv
rtl/page_framebuffer_cursor_writer_top.sv
rtl/pfcw_checker.sv
tb/page_framebuffer_cursor_writer_top_test.sv
